>>> rtl/core/prime_field_arithmetic_unit_assert.svh
// Assertion macros shared by the prime field arithmetic unit RTL.
`ifndef PRIME_FIELD_ARITHMETIC_UNIT_ASSERT_SVH
`define PRIME_FIELD_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent true implies consequent true in the same cycle.
`define PFAU_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent true implies consequent true in the next cycle.
`define PFAU_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFAU_ASSERT_IMPLY(label, ck, rn, ante, cons, msg)
`define PFAU_ASSERT_NEXT(label, ck, rn, ante, cons, msg)
`endif
`endif

>>> rtl/core/pfau_pkg.sv
// Types, constants and helper functions shared by the prime field arithmetic unit.
package pfau_pkg;

    localparam int FIELD_BITS = 31;
    localparam int EXP_BITS   = 32;
    localparam int EXP_CNT_W  = $clog2(EXP_BITS + 1);

    typedef logic [FIELD_BITS-1:0] elem_t;
    typedef logic [EXP_BITS-1:0]   exp_mag_t;
    typedef logic [2:0]            req_op_t;

    localparam elem_t PRIME_RESET = elem_t'(64'd2147483647);

    localparam req_op_t OP_ADD = 3'd0;
    localparam req_op_t OP_SUB = 3'd1;
    localparam req_op_t OP_MUL = 3'd2;
    localparam req_op_t OP_POW = 3'd3;
    localparam req_op_t OP_INV = 3'd4;
    localparam req_op_t OP_DIV = 3'd5;
    localparam req_op_t OP_EQ  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_MUL_WAIT,
        ST_EXP,
        ST_EXP_WAIT,
        ST_POW_BIT,
        ST_POW_MUL_WAIT,
        ST_POW_SQR,
        ST_POW_SQR_WAIT
    } pfau_state_t;

    // What the sequencer does once an exponentiation has finished.
    typedef enum logic [1:0] {
        CONT_NONE,
        CONT_DIV_MUL,
        CONT_EXP_RED
    } pfau_cont_t;

    typedef struct packed {
        logic  start;
        elem_t x;
        elem_t y;
        elem_t p;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        elem_t prod;
    } mm_rsp_t;

    typedef struct packed {
        logic     start;
        exp_mag_t mag;
        elem_t    d;
    } er_req_t;

    typedef struct packed {
        logic  done;
        elem_t rem;
    } er_rsp_t;

    // Modular addition; both operands must already be below p.
    function automatic elem_t add_mod(elem_t x, elem_t y, elem_t p);
        elem_t room;
        room = p - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

endpackage

>>> rtl/core/prime_field_arithmetic_unit.sv
// Top level of the prime field arithmetic unit: request sequencer and result register.
//
// A request beat is taken at a rising edge where start is high and busy is low; busy then
// stays high until the answer is ready, and the answer appears on field_result and
// range_error for exactly one cycle with done high. The receiver cannot stall, so it must
// capture the result beat in that cycle. Add, subtract, equality, an unused code, a
// modulus below two and any out-of-range operand raise done at the rising edge after
// the accepting one. Every other operation runs on one shared modular multiplier that
// performs one shift-and-add step per cycle. Multiply takes one multiplication. Inverse
// is a square-and-multiply over the bits of p - 2, up to two multiplications per
// exponent bit; divide adds one more multiplication. Power first reduces its exponent
// magnitude modulo p - 1 with a bit-serial remainder unit, then exponentiates the same
// way; a negative exponent runs an inverse before that. The prime is written through
// cfg_we and cfg_wdata and must only change while busy is low and no result beat is
// pending.
`include "prime_field_arithmetic_unit_assert.svh"

module prime_field_arithmetic_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  pfau_pkg::elem_t         cfg_wdata,
    input  logic                    start,
    input  pfau_pkg::req_op_t       req_type,
    input  pfau_pkg::elem_t         operand_a,
    input  pfau_pkg::elem_t         operand_b,
    input  logic signed [31:0]      power_exponent,
    output logic                    busy,
    output logic                    done,
    output pfau_pkg::elem_t         field_result,
    output logic                    range_error
);
    import pfau_pkg::*;

    pfau_state_t state_reg, state_next;
    pfau_cont_t  cont_reg, cont_next;
    elem_t       prime_reg;
    req_op_t     op_reg, op_next;
    elem_t       a_reg, a_next;
    elem_t       b_reg, b_next;
    exp_mag_t    mag_reg, mag_next;
    logic        neg_reg, neg_next;
    elem_t       base_reg, base_next;
    elem_t       exp_reg, exp_next;
    elem_t       acc_reg, acc_next;
    elem_t       result_reg, result_next;
    logic        error_reg, error_next;
    logic        done_reg, done_next;

    mm_req_t  mm_req;
    mm_rsp_t  mm_rsp;
    er_req_t  er_req;
    er_rsp_t  er_rsp;

    logic     accept;
    logic     uses_b;
    logic     op_unused;
    logic     operand_bad;
    logic     prime_small;
    exp_mag_t exp_u;
    logic     finish;
    elem_t    fin_result;
    logic     fin_error;

    assign accept = start && (state_reg == ST_IDLE);
    assign exp_u  = $unsigned(power_exponent);

    // Power and inverse only look at the first operand; code seven is unused.
    always_comb
    begin
        uses_b    = 1'b0;
        op_unused = 1'b0;
        case (op_reg) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: uses_b = 1'b1;
            OP_POW, OP_INV:                        uses_b = 1'b0;
            default:                               op_unused = 1'b1;
        endcase
    end

    assign operand_bad = (a_reg >= prime_reg) || (uses_b && (b_reg >= prime_reg));
    assign prime_small = prime_reg < elem_t'(2);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (op_unused || operand_bad || (op_reg == OP_EQ) || prime_small)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (op_reg) inside
                        OP_MUL:                 state_next = ST_MUL;
                        OP_INV, OP_DIV:         state_next = ST_POW_BIT;
                        OP_POW:                 state_next = neg_reg ? ST_POW_BIT : ST_EXP;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXP:
            begin
                state_next = ST_EXP_WAIT;
            end
            ST_EXP_WAIT:
            begin
                if (er_rsp.done)
                begin
                    state_next = ST_POW_BIT;
                end
            end
            ST_POW_BIT:
            begin
                if (exp_reg == '0)
                begin
                    unique case (cont_reg)
                        CONT_NONE:    state_next = ST_IDLE;
                        CONT_DIV_MUL: state_next = ST_MUL;
                        CONT_EXP_RED: state_next = ST_EXP;
                        default:      state_next = ST_IDLE;
                    endcase
                end
                else if (exp_reg[0])
                begin
                    state_next = ST_POW_MUL_WAIT;
                end
                else
                begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                state_next = ((exp_reg >> 1) != '0) ? ST_POW_SQR_WAIT : ST_POW_BIT;
            end
            ST_POW_SQR_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_POW_BIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and unit requests for each state.
    always_comb
    begin
        cont_next  = cont_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        finish     = 1'b0;
        fin_result = '0;
        fin_error  = 1'b0;
        mm_req.start = 1'b0;
        mm_req.x     = acc_reg;
        mm_req.y     = base_reg;
        mm_req.p     = prime_reg;
        er_req.start = 1'b0;
        er_req.mag   = mag_reg;
        er_req.d     = prime_reg - elem_t'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req_type;
                    a_next   = operand_a;
                    b_next   = operand_b;
                    neg_next = exp_u[EXP_BITS-1];
                    // Two's complement magnitude; the most negative value maps to 2^31.
                    mag_next = exp_u[EXP_BITS-1] ? (~exp_u + exp_mag_t'(1)) : exp_u;
                end
            end
            ST_DISPATCH:
            begin
                acc_next  = elem_t'(1);
                cont_next = CONT_NONE;
                if (op_unused)
                begin
                    finish = 1'b1;
                end
                else if (operand_bad)
                begin
                    finish    = 1'b1;
                    fin_error = 1'b1;
                end
                else if (op_reg == OP_EQ)
                begin
                    finish     = 1'b1;
                    fin_result = (a_reg == b_reg) ? elem_t'(1) : '0;
                end
                else if (prime_small)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            finish     = 1'b1;
                            fin_result = add_mod(a_reg, b_reg, prime_reg);
                        end
                        OP_SUB:
                        begin
                            finish     = 1'b1;
                            fin_result = (a_reg >= b_reg) ? (a_reg - b_reg)
                                                          : (a_reg + (prime_reg - b_reg));
                        end
                        OP_INV:
                        begin
                            base_next = a_reg;
                            exp_next  = prime_reg - elem_t'(2);
                        end
                        OP_DIV:
                        begin
                            base_next = b_reg;
                            exp_next  = prime_reg - elem_t'(2);
                            cont_next = CONT_DIV_MUL;
                        end
                        OP_POW:
                        begin
                            base_next = a_reg;
                            if (neg_reg)
                            begin
                                // Invert the base first, then reduce the exponent.
                                exp_next  = prime_reg - elem_t'(2);
                                cont_next = CONT_EXP_RED;
                            end
                        end
                        default:
                        begin
                            finish = 1'b0;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = a_reg;
                mm_req.y     = (op_reg == OP_DIV) ? acc_reg : b_reg;
            end
            ST_MUL_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    finish     = 1'b1;
                    fin_result = mm_rsp.prod;
                end
            end
            ST_EXP:
            begin
                er_req.start = 1'b1;
            end
            ST_EXP_WAIT:
            begin
                if (er_rsp.done)
                begin
                    exp_next  = er_rsp.rem;
                    acc_next  = elem_t'(1);
                    cont_next = CONT_NONE;
                end
            end
            ST_POW_BIT:
            begin
                if (exp_reg == '0)
                begin
                    unique case (cont_reg)
                        CONT_NONE:
                        begin
                            finish     = 1'b1;
                            fin_result = acc_reg;
                        end
                        CONT_EXP_RED:
                        begin
                            base_next = acc_reg;
                        end
                        default:
                        begin
                            finish = 1'b0;
                        end
                    endcase
                end
                else if (exp_reg[0])
                begin
                    mm_req.start = 1'b1;
                end
            end
            ST_POW_MUL_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.prod;
                end
            end
            ST_POW_SQR:
            begin
                // The last square is never needed, so it is skipped.
                exp_next = exp_reg >> 1;
                if ((exp_reg >> 1) != '0)
                begin
                    mm_req.start = 1'b1;
                    mm_req.x     = base_reg;
                end
            end
            ST_POW_SQR_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    base_next = mm_rsp.prod;
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    assign done_next   = finish;
    assign result_next = finish ? fin_result : result_reg;
    assign error_next  = finish ? fin_error : error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cont_reg  <= CONT_NONE;
            prime_reg <= PRIME_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cont_reg  <= cont_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                prime_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        error_reg  <= error_next;
    end

    pfau_mod_mul u_mod_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    pfau_exp_mod u_exp_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (er_req),
        .rsp   (er_rsp)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign field_result = result_reg;
    assign range_error  = error_reg;

    `PFAU_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result beat longer than one cycle")
    `PFAU_ASSERT_IMPLY(a_error_zero, clk, rst_n, done && range_error, field_result == '0, "error beat with nonzero result")
    `PFAU_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not raise busy")

endmodule

>>> rtl/core/pfau_mod_mul.sv
// Iterative modular multiplier: one interleaved shift-and-add step per cycle.
`include "prime_field_arithmetic_unit_assert.svh"

module pfau_mod_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  pfau_pkg::mm_req_t req,
    output pfau_pkg::mm_rsp_t rsp
);
    import pfau_pkg::*;

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    elem_t x_reg, x_next;
    elem_t y_reg, y_next;
    elem_t acc_reg, acc_next;
    elem_t p_reg, p_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        p_next    = p_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            x_next    = req.x;
            y_next    = req.y;
            acc_next  = '0;
            p_next    = req.p;
        end
        else if (busy_reg)
        begin
            // The loop stops as soon as no multiplier bits are left.
            if (y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = y_reg[0] ? add_mod(acc_reg, x_reg, p_reg) : acc_reg;
                x_next   = add_mod(x_reg, x_reg, p_reg);
                y_next   = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    `PFAU_ASSERT_IMPLY(a_mm_no_restart, clk, rst_n, req.start, !busy_reg, "mul restarted while busy")
    `PFAU_ASSERT_IMPLY(a_mm_reduced, clk, rst_n, busy_reg, (acc_reg < p_reg) && (x_reg < p_reg), "mul operand not reduced")
    `PFAU_ASSERT_NEXT(a_mm_done_pulse, clk, rst_n, done_reg, !done_reg, "mul done longer than one cycle")

endmodule

>>> rtl/core/pfau_exp_mod.sv
// Restoring remainder unit that reduces the exponent magnitude, one bit per cycle.
module pfau_exp_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  pfau_pkg::er_req_t req,
    output pfau_pkg::er_rsp_t rsp
);
    import pfau_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [EXP_CNT_W-1:0] cnt_reg, cnt_next;
    exp_mag_t             mag_reg, mag_next;
    elem_t                rem_reg, rem_next;
    elem_t                d_reg, d_next;
    logic [FIELD_BITS:0]  trial;

    assign trial = {rem_reg, mag_reg[EXP_BITS-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = EXP_CNT_W'(EXP_BITS);
            mag_next  = req.mag;
            rem_next  = '0;
            d_next    = req.d;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit and subtract the divisor if it fits.
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = FIELD_BITS'(trial - {1'b0, d_reg});
            end
            else
            begin
                rem_next = FIELD_BITS'(trial);
            end
            mag_next = mag_reg << 1;
            cnt_next = cnt_reg - EXP_CNT_W'(1);
            if (cnt_reg == EXP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> tb/tb_prime_field_arithmetic_unit.sv
// Self-checking testbench for the prime field arithmetic unit with its own answer predictor.
`timescale 1ns / 1ps

module tb_prime_field_arithmetic_unit;

    import pfau_pkg::*;

    // Request code 7 has no operation behind it; the block must answer 0 without an error.
    localparam req_op_t OP_UNUSED = 3'd7;

    // The largest operand value that a request may carry.
    localparam longint unsigned OPERAND_MAX = 64'd2147483646;

    typedef logic signed [31:0] exponent_t;

    // One predicted answer, together with the request that caused it so that a
    // mismatch can be reported with its full context.
    typedef struct {
        req_op_t         op;
        elem_t           a;
        elem_t           b;
        exponent_t       e;
        longint unsigned p;
        elem_t           value;
        logic            err;
    } field_answer_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    elem_t     cfg_wdata;
    logic      start;
    req_op_t   req_type;
    elem_t     operand_a;
    elem_t     operand_b;
    exponent_t power_exponent;
    logic      busy;
    logic      done;
    elem_t     field_result;
    logic      range_error;

    // Answers predicted for accepted request beats, oldest first.
    field_answer_t   pending_answers[$];
    // The modulus that the block currently holds, as far as the testbench knows.
    longint unsigned field_modulus;
    int unsigned     error_count;

    prime_field_arithmetic_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .req_type       (req_type),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .power_exponent (power_exponent),
        .busy           (busy),
        .done           (done),
        .field_result   (field_result),
        .range_error    (range_error)
    );

    // 20 ns clock period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Answer predictor. Operands stay below 2^31, so every product fits
    // in 64 bits and the modular reduction can be taken directly.
    // ------------------------------------------------------------------

    function automatic longint unsigned mod_product(longint unsigned x, longint unsigned y,
                                                    longint unsigned p);
        return (x * y) % p;
    endfunction

    // Square-and-multiply. The accumulator starts at 1, so zero to the power
    // zero comes out as 1, which the block also does.
    function automatic longint unsigned mod_power(longint unsigned base, longint unsigned ex,
                                                  longint unsigned p);
        longint unsigned acc;
        acc = 1;
        while (ex != 0)
        begin
            if (ex[0])
                acc = mod_product(acc, base, p);
            base = mod_product(base, base, p);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic field_answer_t predict_answer(req_op_t op, elem_t a, elem_t b,
                                                     exponent_t e, longint unsigned p);
        field_answer_t   ans;
        longint unsigned av;
        longint unsigned bv;
        longint unsigned mag;
        longint unsigned base;
        longint unsigned r;
        logic            uses_b;
        logic            err;
        ans.op = op;
        ans.a  = a;
        ans.b  = b;
        ans.e  = e;
        ans.p  = p;
        av = a;
        bv = b;
        // The exponent magnitude needs 32 bits so that the most negative value,
        // whose magnitude is 2^31, is carried exactly.
        mag = e[31] ? (64'h1_0000_0000 - {32'b0, e}) : {32'b0, e};
        // Power and inverse take only the first operand; b is ignored there.
        uses_b = (op != OP_POW) && (op != OP_INV);
        err = (av >= p) || (uses_b && (bv >= p));
        r = 0;
        if (op == OP_UNUSED)
            err = 1'b0;
        else if (!err && op == OP_EQ)
            r = (av == bv) ? 1 : 0;
        else if (!err && p >= 2)
        begin
            case (op)
                OP_ADD: r = (av + bv) % p;
                OP_SUB: r = (av + p - bv) % p;
                OP_MUL: r = mod_product(av, bv, p);
                OP_INV: r = mod_power(av, p - 2, p);
                OP_DIV: r = mod_product(av, mod_power(bv, p - 2, p), p);
                default:
                begin
                    // A negative exponent raises the inverse to the reduced magnitude.
                    base = e[31] ? mod_power(av, p - 2, p) : av;
                    r = mod_power(base, mag % (p - 1), p);
                end
            endcase
        end
        ans.value = err ? '0 : elem_t'(r);
        ans.err   = err;
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Result checker. A result beat lasts exactly one cycle and cannot be
    // held off, so it is taken at every rising edge where done is high.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        field_answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                if (error_count < 10)
                    $display("%0t: result beat %0d/%0d with no request outstanding",
                             $realtime, field_result, range_error);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (field_result !== want.value || range_error !== want.err)
                begin
                    if (error_count < 10)
                    begin
                        $display("%0t: op %0d a=%0d b=%0d e=%0d p=%0d", $realtime, want.op,
                                 want.a, want.b, want.e, want.p);
                        $display("    expected %0d/%0d, got %0d/%0d", want.value, want.err,
                                 field_result, range_error);
                    end
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks. Inputs change only at falling edges; the block samples
    // them at the rising edge in between.
    // ------------------------------------------------------------------

    // Presents one request beat and waits until the block takes it. Start is
    // left high on return so that back-to-back beats need no gap; the next
    // beat or a hold-off lowers or reuses it at the following falling edge.
    task automatic send_request(req_op_t op, elem_t a, elem_t b, exponent_t e);
        @(negedge clk);
        start          = 1'b1;
        req_type       = op;
        operand_a      = a;
        operand_b      = b;
        power_exponent = e;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_answers.push_back(predict_answer(op, a, b, e, field_modulus));
    endtask

    // The sender goes quiet for a number of cycles.
    task automatic hold_off(int unsigned cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stops sending and waits until every predicted answer has arrived and the
    // block has dropped busy, so that it is idle.
    task automatic wait_for_answers();
        @(negedge clk);
        start = 1'b0;
        while (pending_answers.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // The modulus may only change while the block is idle.
    task automatic set_field_modulus(longint unsigned p);
        wait_for_answers();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = elem_t'(p);
        @(negedge clk);
        cfg_we    = 1'b0;
        field_modulus = p;
    endtask

    // ------------------------------------------------------------------
    // Random request fields.
    // ------------------------------------------------------------------

    // Power, inverse and divide are slow under large moduli, so those operations
    // are made rare there to keep the run short.
    function automatic req_op_t pick_op(longint unsigned p);
        if (p > 64'd1048576 && $urandom_range(99, 0) < 75)
        begin
            case ($urandom_range(3, 0))
                0:       return OP_ADD;
                1:       return OP_SUB;
                2:       return OP_MUL;
                default: return OP_EQ;
            endcase
        end
        if ($urandom_range(99, 0) < 4)
            return OP_UNUSED;
        return req_op_t'($urandom_range(6, 0));
    endfunction

    // Mostly legal elements, with the edges of the field and some values at or
    // above the modulus that must raise the range error.
    function automatic elem_t pick_operand(longint unsigned p);
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 7)
            return '0;
        if (sel < 14)
            return elem_t'(p - 1);
        if (sel < 20 && p <= OPERAND_MAX)
            return elem_t'($urandom_range(32'(OPERAND_MAX), 32'(p)));
        if (sel < 26)
            return elem_t'($urandom_range(32'(OPERAND_MAX), 0));
        return elem_t'($urandom_range(32'(p - 1), 0));
    endfunction

    // Exponents around zero, the extremes of the signed range and multiples of
    // p - 1, where the reduction wraps, along with fully random ones.
    function automatic exponent_t pick_exponent(longint unsigned p);
        int unsigned     sel;
        longint unsigned m;
        exponent_t       e;
        sel = $urandom_range(99, 0);
        if (sel < 5)
            e = 0;
        else if (sel < 10)
            e = 1;
        else if (sel < 15)
            e = -1;
        else if (sel < 19)
            e = 32'sh7FFF_FFFF;
        else if (sel < 23)
            e = -32'sh7FFF_FFFF;
        else if (sel < 27)
            e = 32'sh8000_0000;
        else if (sel < 45)
        begin
            e = int'($urandom_range(64, 0));
            if ($urandom_range(1, 0))
                e = -e;
        end
        else if (sel < 60)
        begin
            m = longint'($urandom_range(4, 1)) * (p - 1) + $urandom_range(1, 0);
            if (m <= 64'h7FFF_FFFF)
            begin
                e = int'(m);
                if ($urandom_range(1, 0))
                    e = -e;
            end
            else
                e = $urandom;
        end
        else
            e = $urandom;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Edge cases of every operation under the modulus that reset leaves,
    // 2^31 - 1, before any write to the register.
    task automatic test_reset_modulus_edges();
        elem_t top;
        top = elem_t'(field_modulus - 1);
        send_request(OP_ADD, top, top, 0);
        send_request(OP_SUB, '0, 1, 0);
        send_request(OP_MUL, top, top, 0);
        send_request(OP_MUL, '0, top, 0);
        // Zero to the power zero is one.
        send_request(OP_POW, '0, 5, 0);
        // An exponent of p - 1 reduces to zero.
        send_request(OP_POW, 3, 0, exponent_t'(field_modulus - 1));
        send_request(OP_POW, 5, top, 32'sh7FFF_FFFF);
        send_request(OP_POW, 7, 0, -1);
        // The most negative exponent, whose magnitude does not fit in 31 bits.
        send_request(OP_POW, 7, 0, 32'sh8000_0000);
        // Inverse of zero is zero, so a negative power of zero is zero.
        send_request(OP_POW, '0, 0, -5);
        send_request(OP_INV, '0, 0, 0);
        send_request(OP_INV, top, 0, 0);
        // Division by zero gives zero and is no error.
        send_request(OP_DIV, 5, '0, 0);
        send_request(OP_DIV, top, 3, 0);
        send_request(OP_EQ, 12345, 12345, 0);
        send_request(OP_EQ, 12345, 12346, 0);
        send_request(OP_UNUSED, top, top, -1);
    endtask

    // Operands at or above a small modulus; for power and inverse only the
    // first operand counts, so a large second operand must pass.
    task automatic test_range_errors();
        set_field_modulus(13);
        send_request(OP_ADD, 13, 0, 0);
        send_request(OP_POW, 13, 0, 2);
        send_request(OP_POW, 12, elem_t'(OPERAND_MAX), 32'sh8000_0000);
        send_request(OP_INV, 5, elem_t'(OPERAND_MAX), 0);
        send_request(OP_DIV, 3, 13, 0);
        send_request(OP_EQ, 20, 20, 0);
    endtask

    // In the two-element field the exponent p - 2 is zero, so every inverse,
    // that of zero included, is one.
    task automatic test_two_element_field();
        set_field_modulus(2);
        send_request(OP_INV, '0, 0, 0);
        send_request(OP_POW, '0, 0, -1);
        send_request(OP_DIV, 1, '0, 0);
        send_request(OP_SUB, '0, 1, 0);
    endtask

    // One stretch of random requests under one modulus. The sender idles with
    // the given chance per beat, except in every third block of 40 beats, which
    // runs without gaps. Now and then the sender also waits until the block
    // has answered everything.
    task automatic run_random_phase(longint unsigned p, int unsigned beats,
                                    int unsigned idle_pct);
        req_op_t   op;
        elem_t     a;
        elem_t     b;
        exponent_t e;
        set_field_modulus(p);
        for (int unsigned n = 0; n < beats; n++)
        begin
            if ($urandom_range(99, 0) < 3)
                wait_for_answers();
            if (idle_pct != 0 && (n / 40) % 3 != 2 && $urandom_range(99, 0) < idle_pct)
                hold_off($urandom_range(8, 1));
            op = pick_op(p);
            a  = pick_operand(p);
            b  = pick_operand(p);
            e  = pick_exponent(p);
            send_request(op, a, b, e);
        end
    endtask

    // Most beats use small moduli, where power and inverse are quick; a few
    // use the largest moduli. The first group of phases idles the sender a
    // quarter of the time, the second more than half, the last not at all.
    task automatic test_random_traffic();
        run_random_phase(2, 120, 24);
        run_random_phase(3, 120, 24);
        run_random_phase(13, 200, 24);
        run_random_phase(251, 150, 24);
        run_random_phase(5, 120, 57);
        run_random_phase(97, 170, 57);
        run_random_phase(4093, 150, 57);
        run_random_phase(64'd2147483647, 20, 57);
        run_random_phase(7, 200, 0);
        run_random_phase(251, 200, 0);
        run_random_phase(65521, 100, 0);
        run_random_phase(1000003, 40, 0);
        run_random_phase(64'd2147483647, 20, 0);
        run_random_phase(longint'($urandom_range(32'h7FFF_FFFF, 2)), 20, 0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        start          = 1'b0;
        req_type       = OP_ADD;
        operand_a      = '0;
        operand_b      = '0;
        power_exponent = '0;
        field_modulus  = 64'd2147483647;
        error_count    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_modulus_edges();
        test_range_errors();
        test_two_element_field();
        test_random_traffic();

        // Every request yields exactly one answer; after the last one arrives,
        // a further wait makes sure no stray result beat follows.
        wait_for_answers();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: 100 ms is several times the slowest legal run.
    initial
    begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
